// ===== rtl/core/sssm_pkg.sv =====
// Shared types and constants for the spectral SAD match scorer.
package sssm_pkg;

    // Field widths
    localparam int CHAN_W  = 8;
    localparam int CODE_W  = 8;

    // Difference sum: holds the saturation limit 560 * 255 = 142800
    localparam int               SUM_W       = 18;
    localparam logic [SUM_W-1:0] MATCH_LIMIT = 18'd142800;

    // Score divide by 560 = (S >> 4) / 35; the divide by 35 is a reciprocal
    // multiply, ceil(2^20 / 35) = 29960, exact for every shifted sum below 43690
    localparam int                 SCALE_SHIFT = 4;
    localparam int                 SCALED_W    = SUM_W - SCALE_SHIFT;
    localparam int                 RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP_MUL   = 15'd29960;
    localparam int                 RECIP_SHIFT = 20;
    localparam int                 PROD_W      = SCALED_W + RECIP_W;
    localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [QUOT_W-1:0]  MAX_LEVEL   = 9'd255;

    // Command codes on the input channel
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Classified operation carried through the queue
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SAMPLE,
        OP_SKIP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAN_W-1:0] channel;
        logic [CODE_W-1:0] value;
        logic              last;
    } t_entry;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

endpackage

// ===== rtl/core/sssm_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module sssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sssm_front.sv =====
// Front end: accept transactions, classify them and drop loads that fall
// outside the reference table.
module sssm_front #(
    parameter int CHANNELS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_command,
    input  logic [sssm_pkg::CHAN_W-1:0] i_channel,
    input  logic [sssm_pkg::CODE_W-1:0] i_value,
    input  logic                       i_last_of_pixel,
    output logic                       o_entry_valid,
    input  logic                       i_entry_ready,
    output sssm_pkg::t_entry           o_entry
);

    localparam int               LIM_W    = 11;
    localparam logic [LIM_W-1:0] CH_LIMIT = LIM_W'(CHANNELS);

    logic             r_valid;
    sssm_pkg::t_entry r_entry;
    sssm_pkg::t_entry n_entry;
    logic             n_keep;
    logic             w_in_range;
    logic             w_accept;

    assign o_ready  = !r_valid || i_entry_ready;
    assign w_accept = i_valid && o_ready;

    // Classify the incoming transaction
    always_comb begin
        w_in_range = {{(LIM_W - sssm_pkg::CHAN_W){1'b0}}, i_channel} < CH_LIMIT;
        n_entry.channel = i_channel;
        n_entry.value   = i_value;
        n_entry.last    = i_last_of_pixel;
        n_keep          = 1'b1;
        if (i_command == sssm_pkg::CMD_LOAD) begin
            n_entry.op = sssm_pkg::OP_LOAD;
            n_keep     = w_in_range;
        end else if (w_in_range) begin
            n_entry.op = sssm_pkg::OP_SAMPLE;
        end else begin
            n_entry.op = sssm_pkg::OP_SKIP;
        end
    end

    // Hold the classified entry until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= w_accept && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry_valid = r_valid;
    assign o_entry       = r_entry;

endmodule

// ===== rtl/core/sssm_queue.sv =====
// Short register queue between front and back ends.
module sssm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  sssm_pkg::t_entry i_push_entry,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output sssm_pkg::t_entry o_pop_entry
);

    sssm_pkg::t_entry                  r_mem [sssm_pkg::QUEUE_DEPTH];
    logic [sssm_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [sssm_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [sssm_pkg::QCNT_W-1:0]       r_count;
    logic                              w_push;
    logic                              w_pop;

    assign o_push_ready = r_count != sssm_pkg::QCNT_W'(sssm_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_entry  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + sssm_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + sssm_pkg::QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + sssm_pkg::QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - sssm_pkg::QCNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// ===== rtl/core/sssm_back.sv =====
// Back end: reference table, difference accumulation and scoring.
// Stages: table access, accumulate, score into the output register.
module sssm_back #(
    parameter int CHANNELS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_entry_valid,
    output logic                        o_entry_ready,
    input  sssm_pkg::t_entry            i_entry,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sssm_pkg::CODE_W-1:0] o_match_level
);

    localparam int TABLE_MAX = 1 << sssm_pkg::CHAN_W;
    localparam int DEPTH     = (CHANNELS < TABLE_MAX) ? CHANNELS : TABLE_MAX;
    localparam int AW        = $clog2(DEPTH);

    logic                                  w_adv;
    logic                                  w_pop;
    logic                                  w_load;
    logic                                  w_sample;
    logic [AW-1:0]                         w_idx;
    logic [sssm_pkg::CODE_W-1:0]           w_ref;
    logic [DEPTH-1:0]                      r_ref_valid;

    logic                                  r_s1_valid;
    logic                                  r_s1_use;
    logic                                  r_s1_last;
    logic [sssm_pkg::CODE_W-1:0]           r_s1_value;

    logic [sssm_pkg::SUM_W-1:0]            r_sum;
    logic [sssm_pkg::CODE_W-1:0]           w_diff;
    logic [sssm_pkg::SUM_W-1:0]            w_add;
    logic [sssm_pkg::SUM_W-1:0]            n_sum;

    logic                                  r_s2_valid;
    logic [sssm_pkg::SUM_W-1:0]            r_s2_sum;

    logic [sssm_pkg::SCALED_W-1:0]         w_scaled;
    logic [sssm_pkg::PROD_W-1:0]           w_prod;
    logic [sssm_pkg::QUOT_W-1:0]           w_quot;
    logic [sssm_pkg::CODE_W-1:0]           n_level;

    logic                                  r_out_valid;
    logic [sssm_pkg::CODE_W-1:0]           r_out_level;

    // The whole back pipeline moves when the output slot can take a result
    assign w_adv         = !r_out_valid || i_ready;
    assign o_entry_ready = w_adv;
    assign w_pop         = w_adv && i_entry_valid;
    assign w_idx         = i_entry.channel[AW-1:0];

    // Decode the popped operation
    always_comb begin
        w_load   = 1'b0;
        w_sample = 1'b0;
        case (i_entry.op)
            sssm_pkg::OP_LOAD:   w_load   = w_pop;
            sssm_pkg::OP_SAMPLE: w_sample = w_pop;
            sssm_pkg::OP_SKIP:   w_sample = 1'b0;
            default:             w_sample = 1'b0;
        endcase
    end

    sssm_ram #(
        .WIDTH (sssm_pkg::CODE_W),
        .DEPTH (DEPTH)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_idx),
        .i_wdata (i_entry.value),
        .i_re    (w_adv),
        .i_raddr (w_idx),
        .o_rdata (w_ref)
    );

    // Mark channels as loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_valid <= '0;
        end else if (w_load) begin
            r_ref_valid[w_idx] <= 1'b1;
        end
    end

    // Table access stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_pop && (i_entry.op != sssm_pkg::OP_LOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_use   <= w_sample && r_ref_valid[w_idx];
            r_s1_value <= i_entry.value;
            r_s1_last  <= i_entry.last;
        end
    end

    // Accumulate the absolute difference, saturating at the limit
    always_comb begin
        w_diff = (w_ref >= r_s1_value) ? (w_ref - r_s1_value) : (r_s1_value - w_ref);
        if (!r_s1_use) begin
            w_diff = '0;
        end
        w_add = r_sum + {{(sssm_pkg::SUM_W - sssm_pkg::CODE_W){1'b0}}, w_diff};
        n_sum = (w_add > sssm_pkg::MATCH_LIMIT) ? sssm_pkg::MATCH_LIMIT : w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid && r_s1_last;
            if (r_s1_valid) begin
                r_sum <= r_s1_last ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid && r_s1_last) begin
            r_s2_sum <= n_sum;
        end
    end

    // Score: 255 - floor(S / 560), zero at or above the limit
    always_comb begin
        w_scaled = r_s2_sum[sssm_pkg::SUM_W-1:sssm_pkg::SCALE_SHIFT];
        w_prod   = sssm_pkg::PROD_W'(w_scaled) * sssm_pkg::PROD_W'(sssm_pkg::RECIP_MUL);
        w_quot   = w_prod[sssm_pkg::PROD_W-1:sssm_pkg::RECIP_SHIFT];
        if (r_s2_sum >= sssm_pkg::MATCH_LIMIT) begin
            n_level = '0;
        end else begin
            n_level = sssm_pkg::CODE_W'(sssm_pkg::MAX_LEVEL - w_quot);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_out_level <= n_level;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_match_level = r_out_level;

endmodule

// ===== rtl/core/spectral_sad_match_scorer_top.sv =====
// Spectral SAD match scorer.
// Throughput: one transaction per cycle, sustained while the result side keeps up.
// A pixel's last sample passes the front register, the queue, the table read, the
// accumulate stage and the score/output register before its score appears.
// Reset (synchronous, active low) clears all channel valid bits, the running
// sum and the queue; reference codes are kept until overwritten by loads.
module spectral_sad_match_scorer_top #(
    parameter int CHANNELS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_command,
    input  logic [sssm_pkg::CHAN_W-1:0] i_channel,
    input  logic [sssm_pkg::CODE_W-1:0] i_value,
    input  logic                        i_last_of_pixel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sssm_pkg::CODE_W-1:0] o_match_level
);

    logic             w_fq_valid;
    logic             w_fq_ready;
    sssm_pkg::t_entry w_fq_entry;
    logic             w_qb_valid;
    logic             w_qb_ready;
    sssm_pkg::t_entry w_qb_entry;

    sssm_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_channel       (i_channel),
        .i_value         (i_value),
        .i_last_of_pixel (i_last_of_pixel),
        .o_entry_valid   (w_fq_valid),
        .i_entry_ready   (w_fq_ready),
        .o_entry         (w_fq_entry)
    );

    sssm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_entry (w_fq_entry),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_entry  (w_qb_entry)
    );

    sssm_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (w_qb_valid),
        .o_entry_ready (w_qb_ready),
        .i_entry       (w_qb_entry),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_level (o_match_level)
    );

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CHAN        = 256;
    localparam int SCORE_DIVISOR = 560;
    localparam int SCORE_CEILING = SCORE_DIVISOR * 255;
    localparam int HOT_CHANNELS  = 32;
    localparam int PHASE_ITEMS   = 140;
    localparam int SETTLE_CYCLES = 20;

    // Predict the match level of each pixel and hold the scores still owed
    class match_scoreboard;
        bit [sssm_pkg::CODE_W-1:0] ref_code [N_CHAN];
        bit                        ref_loaded [N_CHAN];
        int unsigned               diff_sum;
        bit [sssm_pkg::CODE_W-1:0] pending_levels [$];
        int unsigned               fail_count;

        function void note_input(logic cmd, logic [sssm_pkg::CHAN_W-1:0] ch,
                                 logic [sssm_pkg::CODE_W-1:0] val, logic last);
            int unsigned abs_diff;
            int unsigned level;
            // Load: write the entry and mark it valid; never scores
            if (cmd == sssm_pkg::CMD_LOAD) begin
                if (ch < N_CHAN) begin
                    ref_code[ch]   = val;
                    ref_loaded[ch] = 1'b1;
                end
                return;
            end
            // Sample: accumulate only on loaded channels, saturating at the ceiling
            if (ch < N_CHAN && ref_loaded[ch]) begin
                abs_diff = (ref_code[ch] >= val) ? ref_code[ch] - val : val - ref_code[ch];
                diff_sum += abs_diff;
                if (diff_sum > SCORE_CEILING)
                    diff_sum = SCORE_CEILING;
            end
            if (!last)
                return;
            if (diff_sum >= SCORE_CEILING)
                level = 0;
            else
                level = 255 - diff_sum / SCORE_DIVISOR;
            pending_levels.push_back(level[sssm_pkg::CODE_W-1:0]);
            diff_sum = 0;
        endfunction

        function void check_result(logic [sssm_pkg::CODE_W-1:0] level);
            bit [sssm_pkg::CODE_W-1:0] want;
            if (pending_levels.size() == 0) begin
                $display("%0t: match_level expected none, got %0d", $time, level);
                fail_count++;
                return;
            end
            want = pending_levels.pop_front();
            if (level !== want) begin
                $display("%0t: match_level expected %0d, got %0d", $time, want, level);
                fail_count++;
            end
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic                        i_command = sssm_pkg::CMD_SAMPLE;
    logic [sssm_pkg::CHAN_W-1:0] i_channel = '0;
    logic [sssm_pkg::CODE_W-1:0] i_value = '0;
    logic                        i_last_of_pixel = 1'b0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [sssm_pkg::CODE_W-1:0] o_match_level;

    match_scoreboard scorer = new();
    int send_idle_pct;
    int sink_stall_pct;
    int items_sent;

    spectral_sad_match_scorer_top #(
        .CHANNELS(N_CHAN)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_channel       (i_channel),
        .i_value         (i_value),
        .i_last_of_pixel (i_last_of_pixel),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_match_level   (o_match_level)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Take scores on the result side and stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                scorer.check_result(o_match_level);
            i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Offer one transaction, idling first at random, and hold it until taken
    task automatic send_item(logic cmd, logic [sssm_pkg::CHAN_W-1:0] ch,
                             logic [sssm_pkg::CODE_W-1:0] val, logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_channel       <= ch;
        i_value         <= val;
        i_last_of_pixel <= last;
        do @(posedge i_clk); while (!o_ready);
        scorer.note_input(cmd, ch, val, last);
        items_sent++;
    endtask

    // Hold off the sender until every owed score has come back
    task automatic drain_scores();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (scorer.pending() != 0);
    endtask

    function automatic logic [sssm_pkg::CHAN_W-1:0] pick_channel();
        if ($urandom_range(0, 9) < 8)
            return sssm_pkg::CHAN_W'($urandom_range(0, HOT_CHANNELS - 1));
        return sssm_pkg::CHAN_W'($urandom_range(0, N_CHAN - 1));
    endfunction

    function automatic logic [sssm_pkg::CODE_W-1:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return sssm_pkg::CODE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic pick_flag();
        return 1'($urandom_range(0, 1));
    endfunction

    // Stream one pixel of samples, with the odd stray load mixed in
    task automatic send_pixel(int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(sssm_pkg::CMD_LOAD, pick_channel(), pick_value(), pick_flag());
            send_item(sssm_pkg::CMD_SAMPLE, pick_channel(), pick_value(), i == len - 1);
        end
    endtask

    task automatic run_phase(int send_pct, int sink_pct, int budget);
        int start_count;
        int len;
        send_idle_pct  = send_pct;
        sink_stall_pct = sink_pct;
        start_count    = items_sent;
        // Refresh part of the reference spectrum
        repeat ($urandom_range(8, 24))
            send_item(sssm_pkg::CMD_LOAD, pick_channel(), pick_value(), pick_flag());
        while (items_sent - start_count < budget) begin
            case ($urandom_range(0, 9))
                0: send_item(sssm_pkg::CMD_LOAD, pick_channel(), pick_value(), pick_flag());
                1: send_item(sssm_pkg::CMD_SAMPLE,
                             sssm_pkg::CHAN_W'($urandom_range(0, N_CHAN - 1)),
                             sssm_pkg::CODE_W'($urandom_range(0, 255)), pick_flag());
                default: begin
                    if ($urandom_range(0, 15) == 0)
                        len = $urandom_range(40, 300);
                    else
                        len = $urandom_range(1, 12);
                    send_pixel(len);
                end
            endcase
            if ($urandom_range(0, 19) == 0)
                drain_scores();
        end
        drain_scores();
    endtask

    initial begin
        int len;
        send_idle_pct  = 18;
        sink_stall_pct = 54;
        items_sent     = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty pixel on a channel that was never loaded
        send_item(sssm_pkg::CMD_SAMPLE, 8'd0, 8'd0, 1'b1);
        // Extreme entries; a load carrying the last flag must not score
        send_item(sssm_pkg::CMD_LOAD, 8'd0, 8'd0, 1'b0);
        send_item(sssm_pkg::CMD_LOAD, 8'd255, 8'd255, 1'b0);
        send_item(sssm_pkg::CMD_LOAD, 8'd128, 8'd255, 1'b1);
        // Sum of 560 sits exactly on a step of the score
        send_item(sssm_pkg::CMD_SAMPLE, 8'd7, 8'd200, 1'b0);
        send_item(sssm_pkg::CMD_SAMPLE, 8'd0, 8'd255, 1'b0);
        send_item(sssm_pkg::CMD_SAMPLE, 8'd255, 8'd0, 1'b0);
        send_item(sssm_pkg::CMD_SAMPLE, 8'd128, 8'd205, 1'b1);
        // One short of the step
        send_item(sssm_pkg::CMD_SAMPLE, 8'd0, 8'd255, 1'b0);
        send_item(sssm_pkg::CMD_SAMPLE, 8'd255, 8'd0, 1'b0);
        send_item(sssm_pkg::CMD_SAMPLE, 8'd128, 8'd206, 1'b1);
        // Mid-pixel load with the last flag must leave the sum alone
        send_item(sssm_pkg::CMD_SAMPLE, 8'd0, 8'd255, 1'b0);
        send_item(sssm_pkg::CMD_SAMPLE, 8'd255, 8'd0, 1'b0);
        send_item(sssm_pkg::CMD_LOAD, 8'd9, 8'd0, 1'b1);
        send_item(sssm_pkg::CMD_SAMPLE, 8'd128, 8'd205, 1'b1);
        // Reload overwrites the entry for later samples
        send_item(sssm_pkg::CMD_LOAD, 8'd0, 8'd255, 1'b0);
        send_item(sssm_pkg::CMD_SAMPLE, 8'd0, 8'd255, 1'b1);
        send_item(sssm_pkg::CMD_SAMPLE, 8'd0, 8'd0, 1'b1);
        drain_scores();

        run_phase(18, 54, PHASE_ITEMS);
        run_phase(54, 18, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);

        // Long pixel of full-scale differences drives the sum into saturation
        send_item(sssm_pkg::CMD_LOAD, 8'd40, 8'd0, 1'b0);
        send_item(sssm_pkg::CMD_LOAD, 8'd41, 8'd255, 1'b0);
        len = $urandom_range(560, 600);
        for (int i = 0; i < len; i++) begin
            if (i % 2 == 0)
                send_item(sssm_pkg::CMD_SAMPLE, 8'd40, 8'd255, i == len - 1);
            else
                send_item(sssm_pkg::CMD_SAMPLE, 8'd41, 8'd0, i == len - 1);
        end

        drain_scores();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (scorer.fail_count == 0)
            $display("spectral_sad_match_scorer_top: match");
        else
            $display("spectral_sad_match_scorer_top: mismatch");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #400us;
        $display("spectral_sad_match_scorer_top: mismatch");
        $finish;
    end

endmodule

// ===== spectral_sad_match_scorer_top.f =====
rtl/core/sssm_pkg.sv
rtl/core/sssm_ram.sv
rtl/core/sssm_front.sv
rtl/core/sssm_queue.sv
rtl/core/sssm_back.sv
rtl/core/spectral_sad_match_scorer_top.sv
test/tb.sv
